/* rtl/core/rbo_pkg.sv */
package rbo_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int DATA_W = 16;
    localparam int CMD_W = 2;
    localparam int STAT_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 2'd0,
        CMD_OVERWRITE = 2'd1,
        CMD_READ      = 2'd2,
        CMD_CLEAR     = 2'd3
    } cmd_t;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] read_value;
    } result_t;

endpackage

/* rtl/core/rbo_cell.sv */
module rbo_cell (
    input  logic                        clk,
    input  rbo_pkg::cell_ctrl_t         ctrl,
    input  logic [rbo_pkg::DATA_W-1:0]  write_value,
    input  logic [rbo_pkg::DATA_W-1:0]  neighbor_data,
    output logic [rbo_pkg::DATA_W-1:0]  data
);
    import rbo_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        if (ctrl.load)
        begin
            data_next = write_value;
        end
        else if (ctrl.shift)
        begin
            data_next = neighbor_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* rtl/core/rbo_out_stage.sv */
module rbo_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  rbo_pkg::result_t  in_result,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rbo_pkg::result_t  out_result
);
    import rbo_pkg::*;

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;

    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_valid_reg && !out_ready)
        begin
            if (in_accept)
            begin
                skid_valid_next = 1'b1;
                skid_next       = in_result;
            end
        end
        else if (skid_valid_reg)
        begin
            main_valid_next = 1'b1;
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            main_valid_next = in_accept;
            main_next       = in_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid  = main_valid_reg;
    assign out_result = main_reg;

endmodule

/* rtl/core/ring_buffer_with_overwrite.sv */
// Circular FIFO of 16-bit words with overwrite, built as a row of shifting cells:
// the oldest word sits in cell 0, a read shifts the row down by one, and a write
// loads the cell at the fill count. Every command word yields one result word
// (status, read_value). A command is taken every cycle while the skid register is
// empty; the result goes to an output register backed by that skid register, so the
// input keeps accepting one more word while a result is stalled. Writing capacity
// (0 acts as 1, values above the depth saturate) empties the buffer.
module ring_buffer_with_overwrite (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rbo_pkg::CMD_W-1:0]   command,
    input  logic [rbo_pkg::DATA_W-1:0]  write_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rbo_pkg::STAT_W-1:0]  status,
    output logic [rbo_pkg::DATA_W-1:0]  read_value,
    input  logic                        cfg_wen,
    input  logic [rbo_pkg::CAP_W-1:0]   cfg_wdata
);
    import rbo_pkg::*;

    logic [CAP_W-1:0]  cap_reg;
    logic [CAP_W-1:0]  cap_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  load_idx;
    logic              load_en;
    logic              shift_en;
    logic              accept;
    result_t           result;
    result_t           out_result;
    cmd_t              cmd;
    logic [DATA_W-1:0] cell_data [DEPTH];

    assign accept = in_valid && in_ready;
    assign cmd    = cmd_t'(command);

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (int'(cap_reg) > DEPTH)
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    always_comb
    begin
        count_next        = count_reg;
        load_en           = 1'b0;
        shift_en          = 1'b0;
        load_idx          = count_reg;
        result.status     = ST_OK;
        result.read_value = '0;
        case (cmd)
            CMD_WRITE:
            begin
                if (count_reg >= eff_cap)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    load_en    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_OVERWRITE:
            begin
                load_en = 1'b1;
                if (count_reg < eff_cap)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    shift_en = 1'b1;
                    load_idx = eff_cap - CNT_W'(1);
                end
            end
            CMD_READ:
            begin
                if (count_reg == '0)
                begin
                    result.status = ST_EMPTY;
                end
                else
                begin
                    shift_en          = 1'b1;
                    result.read_value = cell_data[0];
                    count_next        = count_reg - CNT_W'(1);
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign cap_next = cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
        end
        else if (cfg_wen)
        begin
            cap_reg   <= cap_next;
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t        ctrl;
        logic [DATA_W-1:0] nbr;

        assign ctrl.shift = accept && shift_en;
        assign ctrl.load  = accept && load_en && (load_idx == CNT_W'(i));

        if (i == DEPTH - 1)
        begin : g_last
            assign nbr = cell_data[i];
        end
        else
        begin : g_mid
            assign nbr = cell_data[i+1];
        end

        rbo_cell u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .write_value   (write_value),
            .neighbor_data (nbr),
            .data          (cell_data[i])
        );
    end

    rbo_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (accept),
        .in_result  (result),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign status     = out_result.status;
    assign read_value = out_result.read_value;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rbo_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [15:0] value;
    } fifo_op_t;

    localparam int LONG_HOLD_CYCLES = 200;
    localparam int LONG_HOLD_AT     = 500;
    localparam int PHASE_ITEMS      = 150;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CMD_W-1:0]    command = '0;
    logic [DATA_W-1:0]   write_value = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STAT_W-1:0]   status;
    logic [DATA_W-1:0]   read_value;
    logic                cfg_wen = 1'b0;
    logic [CAP_W-1:0]    cfg_wdata = '0;

    // predictor state
    logic [DATA_W-1:0]   word_store [DEPTH];
    int                  wr_ptr;
    int                  rd_ptr;
    int                  fill;
    logic [CAP_W-1:0]    capacity;

    fifo_op_t            pending_ops [$];
    result_t             expected_results [$];
    fifo_op_t            cur_op;

    int                  errors = 0;
    int                  words_sent = 0;
    int                  results_seen = 0;
    int                  full_seen = 0;
    int                  empty_seen = 0;
    int                  cap_writes = 0;
    int                  send_gap = 0;
    int                  hold_left = 0;
    bit                  long_hold_done = 1'b0;
    bit                  quiet = 1'b0;

    ring_buffer_with_overwrite u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int eff_cap();
        if (capacity == 0)
        begin
            return 1;
        end
        if (capacity > DEPTH)
        begin
            return DEPTH;
        end
        return int'(capacity);
    endfunction

    function automatic int next_ptr(int p);
        return (p + 1 >= eff_cap()) ? 0 : p + 1;
    endfunction

    function automatic void push_word(logic [DATA_W-1:0] v);
        word_store[wr_ptr] = v;
        wr_ptr = next_ptr(wr_ptr);
    endfunction

    function automatic result_t fifo_step(cmd_t cmd, logic [DATA_W-1:0] v);
        result_t r;
        int      cap;
        r.status = ST_OK;
        r.read_value = '0;
        cap = eff_cap();
        case (cmd)
            CMD_WRITE:
            begin
                if (fill >= cap)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    push_word(v);
                    fill++;
                end
            end
            CMD_OVERWRITE:
            begin
                push_word(v);
                if (fill < cap)
                begin
                    fill++;
                end
                else
                begin
                    rd_ptr = wr_ptr;
                end
            end
            CMD_READ:
            begin
                if (fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.read_value = word_store[rd_ptr];
                    rd_ptr = next_ptr(rd_ptr);
                    fill--;
                end
            end
            default:
            begin
                wr_ptr = 0;
                rd_ptr = 0;
                fill = 0;
            end
        endcase
        return r;
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic queue_op(cmd_t c, logic [DATA_W-1:0] v);
        pending_ops.push_back('{cmd: c, value: v});
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] v);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        capacity = v;
        wr_ptr = 0;
        rd_ptr = 0;
        fill = 0;
        cap_writes++;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic cmd_t pick_cmd(int bias);
        int r;
        int w_wr;
        int w_ow;
        int w_rd;
        r = $urandom_range(0, 99);
        case (bias)
            0:
            begin
                w_wr = 45;
                w_ow = 25;
                w_rd = 27;
            end
            1:
            begin
                w_wr = 32;
                w_ow = 16;
                w_rd = 48;
            end
            default:
            begin
                w_wr = 20;
                w_ow = 12;
                w_rd = 64;
            end
        endcase
        if (r < w_wr)
        begin
            return CMD_WRITE;
        end
        if (r < w_wr + w_ow)
        begin
            return CMD_OVERWRITE;
        end
        if (r < w_wr + w_ow + w_rd)
        begin
            return CMD_READ;
        end
        return CMD_CLEAR;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            expected_results.push_back(fifo_step(cur_op.cmd, cur_op.value));
            words_sent++;
        end
        if (!in_valid || in_ready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_ops.size() != 0)
            begin
                cur_op = pending_ops.pop_front();
                in_valid <= 1'b1;
                command <= cur_op.cmd;
                write_value <= cur_op.value;
                if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(1, 12);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t exp_r;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                flag_error($sformatf("unexpected result status=%0d read_value=%h",
                                     status, read_value));
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (exp_r.status == ST_FULL)
                begin
                    full_seen++;
                end
                if (exp_r.status == ST_EMPTY)
                begin
                    empty_seen++;
                end
                if (status !== exp_r.status)
                begin
                    flag_error($sformatf("result %0d status %0d, want %0d",
                                         results_seen, status, exp_r.status));
                end
                if (read_value !== exp_r.read_value)
                begin
                    flag_error($sformatf("result %0d read_value %h, want %h",
                                         results_seen, read_value, exp_r.read_value));
                end
            end
        end
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= LONG_HOLD_AT)
        begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            hold_left = $urandom_range(1, 12) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [CAP_W-1:0] phase_caps [11];
        int               bias;
        phase_caps = '{5'd1, 5'd16, 5'd2, 5'd0, 5'd7, 5'd31, 5'd3, 5'd17, 5'd12,
                       5'd4, 5'd16};
        phase_caps[9] = CAP_W'($urandom_range(0, 31));
        capacity = CAP_RESET;
        wr_ptr = 0;
        rd_ptr = 0;
        fill = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset capacity: empty read, extremes, overwrite with room, clear
        queue_op(CMD_READ, 16'h0000);
        queue_op(CMD_WRITE, 16'h0000);
        queue_op(CMD_WRITE, 16'hFFFF);
        queue_op(CMD_OVERWRITE, 16'hA5A5);
        queue_op(CMD_READ, 16'hFFFF);
        queue_op(CMD_READ, 16'h0000);
        queue_op(CMD_READ, 16'h5A5A);
        queue_op(CMD_READ, 16'h0000);
        queue_op(CMD_WRITE, 16'h1234);
        queue_op(CMD_CLEAR, 16'hFFFF);
        queue_op(CMD_READ, 16'h0000);
        wait_drained();

        // zero acts as one: full on write, overwrite drops the oldest
        set_capacity(5'd0);
        queue_op(CMD_WRITE, 16'hFFFF);
        queue_op(CMD_WRITE, 16'h0001);
        queue_op(CMD_OVERWRITE, 16'h8000);
        queue_op(CMD_READ, 16'h0000);
        queue_op(CMD_READ, 16'h0000);
        wait_drained();

        set_capacity(5'd3);
        queue_op(CMD_WRITE, 16'h0011);
        queue_op(CMD_WRITE, 16'h0022);
        queue_op(CMD_WRITE, 16'h0033);
        queue_op(CMD_WRITE, 16'h0044);
        queue_op(CMD_OVERWRITE, 16'h0055);
        queue_op(CMD_OVERWRITE, 16'h0066);
        queue_op(CMD_READ, 16'h0000);
        queue_op(CMD_READ, 16'h0000);
        queue_op(CMD_READ, 16'h0000);
        queue_op(CMD_READ, 16'h0000);
        wait_drained();

        // write a capacity above the depth before the random phases
        set_capacity(5'd31);

        for (int ph = 0; ph < 11; ph++)
        begin
            set_capacity(phase_caps[ph]);
            if (ph == 10)
            begin
                quiet = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 50 == 0)
                begin
                    bias = $urandom_range(0, 2);
                end
                queue_op(pick_cmd(bias), pick_value());
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            flag_error($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("Run covered %0d words and %0d results over %0d capacity writes,",
                 words_sent, results_seen, cap_writes);
        $display("with %0d full and %0d empty statuses seen.", full_seen, empty_seen);
        if (errors == 0)
        begin
            $display("ring_buffer_with_overwrite: match");
        end
        else
        begin
            $display("ring_buffer_with_overwrite: mismatch");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout after %0d words and %0d results", words_sent, results_seen);
        $display("ring_buffer_with_overwrite: mismatch");
        $finish;
    end

endmodule
